// File: rtl/utf8_stream_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_macros.svh
// Assertion macros for the UTF-8 stream decoder. Define NO_ASSERTIONS to
// compile them away. The macros sample on clk and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge out of reset
`define U8SD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("utf8 decoder: invariant violated");

// Check that a condition holds in the cycle after a trigger
`define U8SD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 decoder: sequencing violated");

`else

`define U8SD_ASSERT_ALWAYS(lbl, cond)
`define U8SD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and code-point constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

  // Per-byte result status
  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_MORE  = 2'd1,
    ST_TRUNC = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // Character set tag of a delivered character
  typedef enum logic [1:0] {
    CS_UNICODE  = 2'd0,
    CS_ASCII    = 2'd1,
    CS_LINEDRAW = 2'd2
  } char_set_t;

  // Register index as taken from paddr[2]
  localparam logic REG_IDX_LINEDRAW = 1'b0;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned ACC_W = 31;

  // Code-point limits used by the value check
  localparam logic [ACC_W-1:0] CP_MIN_2B    = 31'h0000_0080;
  localparam logic [ACC_W-1:0] CP_MIN_3B    = 31'h0000_0800;
  localparam logic [ACC_W-1:0] CP_MIN_4B    = 31'h0001_0000;
  localparam logic [ACC_W-1:0] CP_MIN_5B    = 31'h0020_0000;
  localparam logic [ACC_W-1:0] CP_MIN_6B    = 31'h0400_0000;
  localparam logic [ACC_W-1:0] CP_SURR_LO   = 31'h0000_D800;
  localparam logic [ACC_W-1:0] CP_SURR_HI   = 31'h0000_E000;
  localparam logic [ACC_W-1:0] CP_MAX       = 31'h0010_FFFF;
  localparam logic [ACC_W-1:0] CP_NONCHAR_E = 31'h0000_FFFE;
  localparam logic [ACC_W-1:0] CP_NONCHAR_F = 31'h0000_FFFF;
  localparam logic [ACC_W-1:0] CP_TAG_LO    = 31'h000E_0000;
  localparam logic [ACC_W-1:0] CP_TAG_HI    = 31'h000E_007F;
  localparam logic [ACC_W-1:0] CP_BOM       = 31'h0000_FEFF;
  localparam logic [ACC_W-1:0] CP_LSEP      = 31'h0000_2028;
  localparam logic [ACC_W-1:0] CP_PSEP      = 31'h0000_2029;
  localparam logic [ACC_W-1:0] CP_C1_END    = 31'h0000_00A0;
  localparam logic [CP_W-1:0]  CP_NEL       = 21'h00_0085;
  localparam logic [CP_W-1:0]  CP_REPLACE   = 21'h00_FFFD;

  // Outcome of checking a completed multi-byte value
  typedef struct packed {
    status_t           status;
    logic [CP_W-1:0]   code_point;
  } check_res_t;

endpackage

`default_nettype wire

// File: rtl/utf8sd_check.sv
// ----------------------------------------------------------------------------
// utf8sd_check
// Validates and filters a completed multi-byte value: rejects overlong forms,
// surrogates, out-of-range values and FFFE/FFFF, swallows BOM and tag
// characters, maps line/paragraph separators and replaces C1 controls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_check
  import utf8sd_pkg::*;
(
  input  wire logic [ACC_W-1:0] value,
  input  wire logic [2:0]       seq_len,
  output check_res_t            res
);

  logic overlong;
  logic reject;
  logic swallow;

  // Flag forms that a shorter sequence could have carried
  assign overlong = (value < CP_MIN_2B) ||
                    ((value < CP_MIN_3B) && (seq_len >= 3'd3)) ||
                    ((value < CP_MIN_4B) && (seq_len >= 3'd4)) ||
                    ((value < CP_MIN_5B) && (seq_len >= 3'd5)) ||
                    ((value < CP_MIN_6B) && (seq_len >= 3'd6));

  assign reject = overlong ||
                  ((value >= CP_SURR_LO) && (value < CP_SURR_HI)) ||
                  (value > CP_MAX) ||
                  (value == CP_NONCHAR_E) || (value == CP_NONCHAR_F);

  assign swallow = ((value >= CP_TAG_LO) && (value <= CP_TAG_HI)) ||
                   (value == CP_BOM);

  // Select status and mapped value
  always_comb begin
    res.status     = ST_READY;
    res.code_point = value[CP_W-1:0];
    if (reject) begin
      res.status     = ST_BAD;
      res.code_point = '0;
    end else if (swallow) begin
      res.status     = ST_MORE;
      res.code_point = '0;
    end else if ((value == CP_LSEP) || (value == CP_PSEP)) begin
      res.code_point = CP_NEL;
    end else if (value < CP_C1_END) begin
      res.code_point = CP_REPLACE;
    end
  end

endmodule

`default_nettype wire

// File: rtl/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 stream decoder for a terminal: one byte in, one status result out.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while the output is not stalled, and
// returns exactly one result for each byte, in order, via the input and
// result registers. Throughput is one byte per cycle: the whole decode of a
// byte, including the check of a completed value, is a single pass of logic
// between the two registers. With the result register full and stalled, one
// more byte is still taken into the input register. Status 0 carries a
// character, 1 asks for more bytes (also for swallowed BOM and tag
// characters), 2 means the byte broke a sequence and must be sent again, and
// 3 marks an invalid byte or value. Register 0 (linedraw_enable, byte address
// 0) selects the tag of single-byte characters; write it only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_stream_decoder_top_macros.svh"

module utf8_stream_decoder_top
  import utf8sd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // byte request channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  // result request channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [CP_W-1:0]        out_code_point,
  output logic [1:0]             out_char_set,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic              linedraw_r;

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              advance;

  logic [ACC_W-1:0]  partial_r, partial_nxt;
  logic [2:0]        expected_r, expected_nxt;
  logic [2:0]        seen_r, seen_nxt;
  logic [2:0]        seen_inc;
  logic [ACC_W-1:0]  shifted;

  status_t           res_status;
  logic [CP_W-1:0]   res_cp;
  char_set_t         res_cs;
  check_res_t        chk;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [CP_W-1:0]   out_cp_r;
  char_set_t         out_cs_r;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_LINEDRAW) ? {31'b0, linedraw_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linedraw_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_IDX_LINEDRAW)) begin
      linedraw_r <= pwdata[0];
    end
  end

  // Move the held byte on when the result register is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || !out_valid_r || out_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  // Shift in a continuation byte
  assign shifted  = {partial_r[ACC_W-7:0], in_byte_r[5:0]};
  assign seen_inc = seen_r + 3'd1;

  utf8sd_check u_check (
    .value   (shifted),
    .seq_len (expected_r),
    .res     (chk)
  );

  // Decode one byte against the sequence state
  always_comb begin
    partial_nxt  = partial_r;
    expected_nxt = expected_r;
    seen_nxt     = seen_r;
    res_status   = ST_MORE;
    res_cp       = '0;
    res_cs       = CS_UNICODE;
    if (seen_r == 3'd0) begin
      seen_nxt = 3'd1;
      if (!in_byte_r[7]) begin
        seen_nxt   = 3'd0;
        res_status = ST_READY;
        res_cp     = {{(CP_W-8){1'b0}}, in_byte_r};
        res_cs     = linedraw_r ? CS_LINEDRAW : CS_ASCII;
      end else if (in_byte_r[7:5] == 3'b110) begin
        expected_nxt = 3'd2;
        partial_nxt  = {{(ACC_W-5){1'b0}}, in_byte_r[4:0]};
      end else if (in_byte_r[7:4] == 4'b1110) begin
        expected_nxt = 3'd3;
        partial_nxt  = {{(ACC_W-4){1'b0}}, in_byte_r[3:0]};
      end else if (in_byte_r[7:3] == 5'b11110) begin
        expected_nxt = 3'd4;
        partial_nxt  = {{(ACC_W-3){1'b0}}, in_byte_r[2:0]};
      end else if (in_byte_r[7:2] == 6'b111110) begin
        expected_nxt = 3'd5;
        partial_nxt  = {{(ACC_W-2){1'b0}}, in_byte_r[1:0]};
      end else if (in_byte_r[7:1] == 7'b1111110) begin
        expected_nxt = 3'd6;
        partial_nxt  = {{(ACC_W-1){1'b0}}, in_byte_r[0]};
      end else begin
        // stray continuation or FE/FF lead: reject, stay idle
        seen_nxt   = 3'd0;
        res_status = ST_BAD;
      end
    end else if (in_byte_r[7:6] != 2'b10) begin
      // sequence broken: drop it and ask for the byte again
      partial_nxt  = '0;
      expected_nxt = 3'd0;
      seen_nxt     = 3'd0;
      res_status   = ST_TRUNC;
    end else if (seen_inc < expected_r) begin
      partial_nxt = shifted;
      seen_nxt    = seen_inc;
    end else begin
      // sequence complete: return to idle and deliver the checked value
      partial_nxt  = '0;
      expected_nxt = 3'd0;
      seen_nxt     = 3'd0;
      res_status   = chk.status;
      res_cp       = chk.code_point;
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r  <= '0;
      expected_r <= 3'd0;
      seen_r     <= 3'd0;
    end else if (advance) begin
      partial_r  <= partial_nxt;
      expected_r <= expected_nxt;
      seen_r     <= seen_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= res_status;
      out_cp_r     <= res_cp;
      out_cs_r     <= res_cs;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_code_point = out_cp_r;
  assign out_char_set   = out_cs_r;

  // Assertions
  `U8SD_ASSERT_ALWAYS(a_seen_below_len, (seen_r == 3'd0) || (seen_r < expected_r))
  `U8SD_ASSERT_ALWAYS(a_empty_payload, !out_valid_r || (out_status_r == ST_READY) || ((out_cp_r == '0) && (out_cs_r == CS_UNICODE)))
  `U8SD_ASSERT_ALWAYS(a_single_byte_tag, !out_valid_r || (out_cs_r == CS_UNICODE) || (out_cp_r < 21'h80))
  `U8SD_ASSERT_NEXT(a_hold_stalled_byte, in_valid_r && !advance, in_valid_r && $stable(in_byte_r))

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 stream decoder. Bytes go in over a
// valid/ready channel and every result is checked, field by field and in
// order, against a behavioural decoder kept in step with the block. A short
// table of directed bytes comes first. Random traffic follows: mostly
// well-formed sequences aimed at the value checks, plus broken sequences and
// noise. The line-drawing tag is toggled between phases through the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import utf8sd_pkg::*;

  localparam logic [2:0] LINEDRAW_ADDR = 3'd0;
  localparam logic [2:0] SPARE_ADDR    = 3'd4;
  localparam int         PHASE_BYTES   = 125;

  typedef struct packed {
    status_t         status;
    logic [CP_W-1:0] code_point;
    char_set_t       char_set;
  } dec_result_t;

  typedef struct {
    logic [7:0]  b;
    bit          typed;
    dec_result_t res;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [CP_W-1:0]   out_code_point;
  logic [1:0]        out_char_set;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Decoder state mirrored by the bench
  logic [ACC_W-1:0]  seq_acc;
  logic [2:0]        seq_len;
  logic [2:0]        seq_seen;
  logic              linedraw_on;

  dec_result_t       pending_results[$];
  dir_row_t          directed_rows[$];
  dec_result_t       no_typed;
  int                mismatch_cnt;
  int                bytes_sent;
  bit                no_idle;

  utf8_stream_decoder_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_code_point (out_code_point),
    .out_char_set   (out_char_set),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Classify a completed multi-byte value
  function automatic dec_result_t check_value(input logic [ACC_W-1:0] v,
                                              input logic [2:0] len);
    dec_result_t r;
    logic        overlong;
    r.status     = ST_READY;
    r.code_point = '0;
    r.char_set   = CS_UNICODE;
    overlong = (v < CP_MIN_2B) || (len >= 3'd3 && v < CP_MIN_3B) ||
               (len >= 3'd4 && v < CP_MIN_4B) || (len >= 3'd5 && v < CP_MIN_5B) ||
               (len >= 3'd6 && v < CP_MIN_6B);
    if (overlong || (v >= CP_SURR_LO && v < CP_SURR_HI) || v > CP_MAX ||
        v == CP_NONCHAR_E || v == CP_NONCHAR_F) begin
      r.status = ST_BAD;
    end else if ((v >= CP_TAG_LO && v <= CP_TAG_HI) || v == CP_BOM) begin
      r.status = ST_MORE;
    end else if (v == CP_LSEP || v == CP_PSEP) begin
      r.code_point = CP_NEL;
    end else if (v < CP_C1_END) begin
      r.code_point = CP_REPLACE;
    end else begin
      r.code_point = v[CP_W-1:0];
    end
    return r;
  endfunction

  // Advance the mirrored decoder by one byte and return its result
  function automatic dec_result_t decode_byte(input logic [7:0] b);
    dec_result_t      r;
    logic [ACC_W-1:0] v;
    logic [2:0]       len;
    r.status     = ST_MORE;
    r.code_point = '0;
    r.char_set   = CS_UNICODE;
    if (seq_seen == 3'd0) begin
      if (!b[7]) begin
        r.status     = ST_READY;
        r.code_point = {13'd0, b};
        r.char_set   = linedraw_on ? CS_LINEDRAW : CS_ASCII;
      end else if (b[7:5] == 3'b110) begin
        seq_len = 3'd2; seq_acc = {26'd0, b[4:0]}; seq_seen = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
        seq_len = 3'd3; seq_acc = {27'd0, b[3:0]}; seq_seen = 3'd1;
      end else if (b[7:3] == 5'b11110) begin
        seq_len = 3'd4; seq_acc = {28'd0, b[2:0]}; seq_seen = 3'd1;
      end else if (b[7:2] == 6'b111110) begin
        seq_len = 3'd5; seq_acc = {29'd0, b[1:0]}; seq_seen = 3'd1;
      end else if (b[7:1] == 7'b1111110) begin
        seq_len = 3'd6; seq_acc = {30'd0, b[0]}; seq_seen = 3'd1;
      end else begin
        r.status = ST_BAD;
      end
    end else if (b[7:6] != 2'b10) begin
      // Sequence broken: drop it, the byte has to come again
      seq_acc = '0; seq_len = '0; seq_seen = '0;
      r.status = ST_TRUNC;
    end else begin
      seq_acc  = {seq_acc[ACC_W-7:0], b[5:0]};
      seq_seen = seq_seen + 3'd1;
      if (seq_seen >= seq_len) begin
        v   = seq_acc;
        len = seq_len;
        seq_acc = '0; seq_len = '0; seq_seen = '0;
        r = check_value(v, len);
      end
    end
    return r;
  endfunction

  // Send one byte request and queue what it should produce
  task automatic send_byte(input logic [7:0] b, input bit typed_ok,
                           input dec_result_t typed_res);
    int          gap;
    dec_result_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    pred = decode_byte(b);
    pending_results.push_back(typed_ok ? typed_res : pred);
    bytes_sent++;
  endtask

  // Encode a value in len bytes; if cut is below len, stop after cut bytes and break the sequence
  task automatic send_char(input logic [ACC_W-1:0] v, input int len, input int cut);
    logic [ACC_W-1:0] sh;
    logic [7:0]       b;
    int               k;
    if (len == 1) begin
      send_byte({1'b0, v[6:0]}, 1'b0, no_typed);
    end else begin
      sh = v >> (6 * (len - 1));
      case (len)
        2:       b = {3'b110, sh[4:0]};
        3:       b = {4'b1110, sh[3:0]};
        4:       b = {5'b11110, sh[2:0]};
        5:       b = {6'b111110, sh[1:0]};
        default: b = {7'b1111110, sh[0]};
      endcase
      send_byte(b, 1'b0, no_typed);
      for (k = len - 2; k >= 0 && (len - 1 - k) < cut; k--) begin
        sh = v >> (6 * k);
        send_byte({2'b10, sh[5:0]}, 1'b0, no_typed);
      end
      if (cut < len) begin
        // Break with a non-continuation byte, then resend it
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        send_byte(b, 1'b0, no_typed);
        send_byte(b, 1'b0, no_typed);
      end
    end
  endtask

  // Pick a value aimed at one of the value checks
  function automatic logic [ACC_W-1:0] pick_code_value();
    logic [31:0] raw;
    case ($urandom_range(0, 9))
      0:       return ACC_W'($urandom_range(0, 'h7F));
      1:       return ACC_W'('h80 + $urandom_range(0, 'h20));
      2:       return ACC_W'(CP_SURR_LO + $urandom_range(0, 'h7FF));
      3:       return ACC_W'(CP_NONCHAR_E + $urandom_range(0, 1));
      4:       return CP_BOM;
      5:       return ACC_W'(CP_LSEP + $urandom_range(0, 1));
      6:       return ACC_W'(CP_TAG_LO + $urandom_range(0, 'h80));
      7:       return ACC_W'(CP_MAX + $urandom_range(0, 2));
      default: begin
        raw = $urandom >> $urandom_range(1, 31);
        return raw[ACC_W-1:0];
      end
    endcase
  endfunction

  // Hold the input low and wait for every queued result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_xfer(input logic wr, input logic [2:0] addr,
                          input logic [31:0] data, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a register, mirror it, and read the line-drawing bit back
  task automatic set_reg(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    apb_xfer(1'b1, addr, data, rd);
    if (addr[2] == REG_IDX_LINEDRAW) linedraw_on = data[0];
    apb_xfer(1'b0, LINEDRAW_ADDR, '0, rd);
    if (rd[0] !== linedraw_on) begin
      mismatch_cnt++;
      $display("%0t: linedraw_enable readback: expected %0d, got %0d",
               $time, linedraw_on, rd[0]);
    end
  endtask

  task automatic add_row(input logic [7:0] b, input status_t st,
                         input logic [CP_W-1:0] cp, input char_set_t cs);
    dir_row_t row;
    row.b = b; row.typed = 1'b1;
    row.res.status = st; row.res.code_point = cp; row.res.char_set = cs;
    directed_rows.push_back(row);
  endtask

  task automatic add_pred(input logic [7:0] b);
    dir_row_t row;
    row.b = b; row.typed = 1'b0; row.res = no_typed;
    directed_rows.push_back(row);
  endtask

  // Result side: random stall per result, then check against the queue
  initial begin
    int          stall;
    dec_result_t want;
    out_ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && rst_n === 1'b1));
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with nothing expected: status %0d code point %h char set %0d",
                 $time, out_status, out_code_point, out_char_set);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_code_point !== want.code_point ||
            out_char_set !== want.char_set) begin
          mismatch_cnt++;
          $display("%0t: expected status %0d code point %h char set %0d, %s %0d %h %0d",
                   $time, want.status, want.code_point, want.char_set, "got",
                   out_status, out_code_point, out_char_set);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int               r;
    int               len;
    int               cut;
    int               target;
    logic [ACC_W-1:0] v;
    logic [31:0]      data;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    seq_acc = '0; seq_len = '0; seq_seen = '0;
    linedraw_on  = 1'b0;
    mismatch_cnt = 0;
    bytes_sent   = 0;
    no_idle      = 1'b0;
    no_typed.status = ST_READY; no_typed.code_point = '0; no_typed.char_set = CS_UNICODE;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Field extremes and bad leads, ascii tag at reset value
    add_row(8'h00, ST_READY, 21'h00, CS_ASCII);
    add_row(8'h7F, ST_READY, 21'h7F, CS_ASCII);
    add_row(8'h80, ST_BAD, '0, CS_UNICODE);
    add_row(8'hFF, ST_BAD, '0, CS_UNICODE);
    // Overlong two-byte zero
    add_row(8'hC0, ST_MORE, '0, CS_UNICODE);
    add_row(8'h80, ST_BAD, '0, CS_UNICODE);
    // Sequence cut short by a plain byte
    add_row(8'hC2, ST_MORE, '0, CS_UNICODE);
    add_row(8'h41, ST_TRUNC, '0, CS_UNICODE);
    // Line separator maps to next-line
    add_row(8'hE2, ST_MORE, '0, CS_UNICODE);
    add_row(8'h80, ST_MORE, '0, CS_UNICODE);
    add_pred(8'hA8);
    // Byte order mark is swallowed
    add_pred(8'hEF);
    add_pred(8'hBB);
    add_row(8'hBF, ST_MORE, '0, CS_UNICODE);
    // C1 control becomes the replacement character
    add_pred(8'hC2);
    add_row(8'h80, ST_READY, CP_REPLACE, CS_UNICODE);
    // Tag character
    add_pred(8'hF3);
    add_pred(8'hA0);
    add_pred(8'h80);
    add_pred(8'h81);
    // Six-byte sequence with every value bit set
    add_pred(8'hFD);
    repeat (4) add_pred(8'hBF);
    add_row(8'hBF, ST_BAD, '0, CS_UNICODE);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].res);

    // Random phases, line-drawing tag alternating
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      data    = $urandom;
      data[0] = (p % 2 == 0);
      set_reg(LINEDRAW_ADDR, data);
      if (p == 0) begin
        // Spare address must not disturb the tag
        data    = $urandom;
        data[0] = 1'b0;
        set_reg(SPARE_ADDR, data);
      end
      no_idle = (p == 2);
      target  = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
        r = $urandom_range(0, 99);
        if (r < 15) begin
          send_byte(8'($urandom), 1'b0, no_typed);
        end else begin
          v = pick_code_value();
          if (v < CP_MIN_2B)      len = 1;
          else if (v < CP_MIN_3B) len = 2;
          else if (v < CP_MIN_4B) len = 3;
          else if (v < CP_MIN_5B) len = 4;
          else if (v < CP_MIN_6B) len = 5;
          else                    len = 6;
          // Stretch some into overlong forms
          if ($urandom_range(0, 3) == 0) len = $urandom_range(len, 6);
          cut = len;
          if (r < 27 && len > 1) cut = $urandom_range(1, len - 1);
          send_char(v, len, cut);
        end
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
